@@ design/rba_pkg.sv @@
// Shared types and codes for the reference-counted block allocator.
// No dependencies; imported by every module of the block but rba_ram.
package rba_pkg;

	localparam int CFG_W      = 11;
	localparam int BLK_W      = 10;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_ADDREF = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OOM  = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;
	localparam logic [1:0] ST_NULL = 2'd3;

	localparam logic REG_POOL = 1'b0;

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

endpackage

@@ design/rba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/rba_ctrl.sv @@
// Controller for the block allocator: accept / execute sequencing.
// Depends on rba_pkg.
module rba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_ready,
	input  logic          out_full,
	output rba_pkg::cmd_t cmd
);
	import rba_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	assign in_ready    = (state_q == S_IDLE);
	assign cmd.capture = in_valid && (state_q == S_IDLE);
	assign cmd.commit  = (state_q == S_EXEC) && (!out_full || out_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.capture) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (cmd.commit) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/rba_dp.sv @@
// Datapath for the block allocator: free list, counts, usage and result register.
// Depends on rba_pkg and rba_ram.
module rba_dp #(
	parameter int MAX_BLOCKS = 1024,
	parameter int REF_BITS   = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rba_pkg::cmd_t              cmd,
	input  logic [1:0]                 opcode,
	input  logic                       block_present,
	input  logic [rba_pkg::BLK_W-1:0]  block_index,
	input  logic                       cfg_we,
	input  logic [rba_pkg::CFG_W-1:0]  cfg_wdata,
	output logic [rba_pkg::CFG_W-1:0]  pool_rd,
	input  logic                       out_ready,
	output logic                       out_full,
	output logic [1:0]                 status,
	output logic [rba_pkg::BLK_W-1:0]  granted_block,
	output logic [rba_pkg::CFG_W-1:0]  used_count,
	output logic [rba_pkg::CFG_W-1:0]  used_peak
);
	import rba_pkg::*;

	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int POOL_RESET = (MAX_BLOCKS < 1024) ? MAX_BLOCKS : 1024;
	localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

	// pool size, free head, fresh mark (blocks never yet popped start here)
	logic [CNT_W-1:0] pool_q, head_q, fresh_q, used_q, peak_q;
	logic [CNT_W-1:0] head_d, fresh_d, used_d, peak_d;

	logic [1:0]       op_q;
	logic             present_q;
	logic [BLK_W-1:0] blk_q;

	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [BLK_W-1:0] granted_q;
	logic [CFG_W-1:0] used_out_q, peak_out_q;

	logic [CNT_W-1:0]    link_rd;
	logic [REF_BITS-1:0] cnt_rd;
	logic                link_we, cnt_we;
	logic [IDX_W-1:0]    cnt_waddr;
	logic [REF_BITS-1:0] cnt_wdata;
	logic [1:0]          st_d;
	logic [BLK_W-1:0]    granted_d;

	logic [31:0] head32, pool32, fresh32, blk32, used32, nxt32, cfg32, sat32;

	rba_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BLOCKS)) u_link_ram (
		.clk   (clk),
		.we    (cmd.commit && link_we),
		.waddr (IDX_W'(blk_q)),
		.wdata (head_q),
		.re    (cmd.capture),
		.raddr (head_q[IDX_W-1:0]),
		.rdata (link_rd)
	);

	rba_ram #(.WIDTH(REF_BITS), .DEPTH(MAX_BLOCKS)) u_cnt_ram (
		.clk   (clk),
		.we    (cmd.commit && cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cmd.capture),
		.raddr (IDX_W'(block_index)),
		.rdata (cnt_rd)
	);

	assign head32  = 32'(head_q);
	assign pool32  = 32'(pool_q);
	assign fresh32 = 32'(fresh_q);
	assign blk32   = 32'(blk_q);
	assign used32  = 32'(used_q);
	assign cfg32   = 32'(cfg_wdata);

	always_comb begin
		sat32 = cfg32;
		if (cfg32 == 32'd0) sat32 = 32'd1;
		if (cfg32 > 32'(MAX_BLOCKS)) sat32 = 32'(MAX_BLOCKS);
	end

	always_comb begin
		head_d    = head_q;
		fresh_d   = fresh_q;
		used_d    = used_q;
		peak_d    = peak_q;
		link_we   = 1'b0;
		cnt_we    = 1'b0;
		cnt_waddr = IDX_W'(blk_q);
		cnt_wdata = cnt_rd;
		st_d      = ST_OK;
		granted_d = '0;
		nxt32     = 32'd0;
		case (op_q)
			OP_ALLOC: begin
				if (head32 >= pool32) begin
					st_d = ST_OOM;
				end else begin
					if (head_q == fresh_q) begin
						nxt32   = head32 + 32'd1;
						fresh_d = CNT_W'(fresh32 + 32'd1);
					end else begin
						nxt32 = 32'(link_rd);
					end
					if (nxt32 > pool32) nxt32 = pool32;
					head_d    = CNT_W'(nxt32);
					cnt_we    = 1'b1;
					cnt_waddr = head_q[IDX_W-1:0];
					cnt_wdata = REF_BITS'(1);
					granted_d = head32[BLK_W-1:0];
					if (used32 < pool32) used_d = CNT_W'(used32 + 32'd1);
					if (used_d > peak_q) peak_d = used_d;
				end
			end
			OP_FREE, OP_ADDREF: begin
				if (!present_q) begin
					st_d = ST_NULL;
				end else if (blk32 >= pool32 || blk32 >= fresh32 || cnt_rd == '0) begin
					st_d = ST_BAD;
				end else if (op_q == OP_ADDREF) begin
					if (cnt_rd < REF_MAX) begin
						cnt_we    = 1'b1;
						cnt_wdata = cnt_rd + 1'b1;
					end
				end else if (cnt_rd > REF_BITS'(1)) begin
					cnt_we    = 1'b1;
					cnt_wdata = cnt_rd - 1'b1;
				end else begin
					cnt_we    = 1'b1;
					cnt_wdata = '0;
					link_we   = 1'b1;
					head_d    = CNT_W'(blk32);
					if (used_q != '0) used_d = used_q - 1'b1;
				end
			end
			default: st_d = ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= opcode;
			present_q <= block_present;
			blk_q     <= block_index;
		end
		if (cmd.commit) begin
			status_q   <= st_d;
			granted_q  <= granted_d;
			used_out_q <= CFG_W'(32'(used_d));
			peak_out_q <= CFG_W'(32'(peak_d));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q      <= CNT_W'(POOL_RESET);
			head_q      <= '0;
			fresh_q     <= '0;
			used_q      <= '0;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pool_q  <= CNT_W'(sat32);
				head_q  <= '0;
				fresh_q <= '0;
				used_q  <= '0;
				peak_q  <= '0;
			end else if (cmd.commit) begin
				head_q  <= head_d;
				fresh_q <= fresh_d;
				used_q  <= used_d;
				peak_q  <= peak_d;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pool_rd       = CFG_W'(pool32);
	assign out_full      = out_valid_q;
	assign status        = status_q;
	assign granted_block = granted_q;
	assign used_count    = used_out_q;
	assign used_peak     = peak_out_q;

endmodule

@@ design/refcounted_block_allocator_top.sv @@
// Top level of the reference-counted block allocator.
// Depends on rba_pkg, rba_ctrl, rba_dp (and through it rba_ram).
//
//  port group  | handshake             | payload
//  ------------+-----------------------+----------------------------------------------
//  request     | in_valid / in_ready   | opcode, block_present, block_index
//  result      | out_valid / out_ready | status, granted_block, used_count, used_peak
//  config APB  | psel, penable, pready | pwrite, paddr, pwdata, prdata
//
// An item is accepted only when idle; the accept edge launches synchronous reads of
// the link and count memories, the commit edge updates the free list and loads the
// result register, and a full result register not taken holds the item in execution.
// No clearing pass after reset: a fresh-block mark stands in for the link memory's
// initial contents. A pool_blocks write rebuilds the pool.
module refcounted_block_allocator_top #(
	parameter int MAX_BLOCKS = 1024,
	parameter int REF_BITS   = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rba_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [rba_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [rba_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       opcode,
	input  logic                             block_present,
	input  logic [rba_pkg::BLK_W-1:0]        block_index,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       status,
	output logic [rba_pkg::BLK_W-1:0]        granted_block,
	output logic [rba_pkg::CFG_W-1:0]        used_count,
	output logic [rba_pkg::CFG_W-1:0]        used_peak
);
	import rba_pkg::*;

	cmd_t             cmd;
	logic             out_full;
	logic             cfg_we;
	logic [CFG_W-1:0] pool_rd;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_POOL);
	assign prdata = (paddr[2] == REG_POOL) ? APB_DATA_W'(pool_rd) : '0;
	assign out_valid = out_full;

	rba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_full  (out_full),
		.cmd       (cmd)
	);

	rba_dp #(.MAX_BLOCKS(MAX_BLOCKS), .REF_BITS(REF_BITS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.opcode        (opcode),
		.block_present (block_present),
		.block_index   (block_index),
		.cfg_we        (cfg_we),
		.cfg_wdata     (pwdata[CFG_W-1:0]),
		.pool_rd       (pool_rd),
		.out_ready     (out_ready),
		.out_full      (out_full),
		.status        (status),
		.granted_block (granted_block),
		.used_count    (used_count),
		.used_peak     (used_peak)
	);

endmodule

@@ tb/rba_reply_checker.sv @@
// Reply checker for the block allocator: mirrors the free list, counts and pool register,
// predicts one reply per accepted item and compares it with the result channel.
// Depends on rba_pkg; instantiated beside the DUT by tb_refcounted_block_allocator_top.
module rba_reply_checker #(
	parameter int MAX_BLOCKS = 1024,
	parameter int REF_BITS   = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [rba_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rba_pkg::APB_DATA_W-1:0] pwdata,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [1:0]                     opcode,
	input  logic                           block_present,
	input  logic [rba_pkg::BLK_W-1:0]      block_index,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [1:0]                     status,
	input  logic [rba_pkg::BLK_W-1:0]      granted_block,
	input  logic [rba_pkg::CFG_W-1:0]      used_count,
	input  logic [rba_pkg::CFG_W-1:0]      used_peak,
	output int                             errors,
	output int                             outstanding,
	output int                             pool_size,
	output logic [MAX_BLOCKS-1:0]          live_map,
	output logic [MAX_BLOCKS-1:0]          seen_map
);
	timeunit 1ns;
	timeprecision 1ps;
	import rba_pkg::*;

	localparam int REF_TOP = (1 << REF_BITS) - 1;

	typedef struct packed {
		logic [1:0]       status;
		logic [BLK_W-1:0] granted;
		logic [CFG_W-1:0] used;
		logic [CFG_W-1:0] peak;
	} reply_t;

	reply_t              owed[$];
	reply_t              want;
	int                  link_of[MAX_BLOCKS];
	logic [REF_BITS-1:0] refs[MAX_BLOCKS];
	int                  head;
	int                  in_use;
	int                  peak;
	int                  new_size;

	function automatic void rebuild_pool();
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			link_of[i] = (i < pool_size) ? i + 1 : pool_size;
			refs[i] = '0;
		end
		live_map = '0;
		head = 0;
		in_use = 0;
		peak = 0;
	endfunction

	function automatic reply_t apply_request(logic [1:0] op, logic named,
			logic [BLK_W-1:0] idx);
		reply_t r;
		int     b;
		r = '0;
		r.status = ST_OK;
		if (op == OP_ALLOC) begin
			if (head >= pool_size) begin
				r.status = ST_OOM;
			end else begin
				b = head;
				head = (link_of[b] > pool_size) ? pool_size : link_of[b];
				refs[b] = 1;
				live_map[b] = 1'b1;
				seen_map[b] = 1'b1;
				r.granted = b[BLK_W-1:0];
				if (in_use < pool_size)
					in_use++;
				if (in_use > peak)
					peak = in_use;
			end
		end else if (op == OP_FREE || op == OP_ADDREF) begin
			if (!named) begin
				r.status = ST_NULL;
			end else if (idx >= pool_size || refs[idx] == 0) begin
				r.status = ST_BAD;
			end else if (op == OP_ADDREF) begin
				if (refs[idx] != REF_TOP)
					refs[idx]++;
			end else if (refs[idx] > 1) begin
				refs[idx]--;
			end else begin
				refs[idx] = '0;
				live_map[idx] = 1'b0;
				link_of[idx] = head;
				head = idx;
				if (in_use > 0)
					in_use--;
			end
		end
		r.used = in_use[CFG_W-1:0];
		r.peak = peak[CFG_W-1:0];
		return r;
	endfunction

	task automatic compare_field(string what, logic [CFG_W-1:0] exp_v,
			logic [CFG_W-1:0] got_v);
		if (exp_v !== got_v) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, what, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size = (MAX_BLOCKS < 1024) ? MAX_BLOCKS : 1024;
			rebuild_pool();
			seen_map = '0;
			owed.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			// pool write: mask to the register width, clamp, then rebuild
			if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1:2] == REG_POOL) begin
				new_size = pwdata[CFG_W-1:0];
				if (new_size < 1)
					new_size = 1;
				if (new_size > MAX_BLOCKS)
					new_size = MAX_BLOCKS;
				pool_size = new_size;
				rebuild_pool();
			end
			if (out_valid && out_ready) begin
				if (owed.size() == 0) begin
					errors++;
					$display("%0t: unexpected reply, status %0d granted %0d used %0d",
						$time, status, granted_block, used_count);
				end else begin
					want = owed.pop_front();
					compare_field("status", want.status, status);
					compare_field("granted_block", want.granted, granted_block);
					compare_field("used_count", want.used, used_count);
					compare_field("used_peak", want.peak, used_peak);
				end
			end
			if (in_valid && in_ready)
				owed.push_back(apply_request(opcode, block_present, block_index));
			outstanding = owed.size();
		end
	end

endmodule

@@ tb/tb_refcounted_block_allocator_top.sv @@
// Stimulus and verdict for the reference-counted block allocator.
// Depends on rba_pkg, refcounted_block_allocator_top and rba_reply_checker.
module tb_refcounted_block_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rba_pkg::*;

	localparam int                    MAX_BLOCKS      = 1024;
	localparam int                    CYCLE_LIMIT     = 300000;
	localparam logic [1:0]            OP_UNUSED       = 2'd3;
	localparam logic [APB_ADDR_W-1:0] POOL_ADDR       = {REG_POOL, 2'b00};
	localparam logic [APB_ADDR_W-1:0] UNUSED_REG_ADDR = {~REG_POOL, 2'b00};

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  psel          = 1'b0;
	logic                  penable       = 1'b0;
	logic                  pwrite        = 1'b0;
	logic [APB_ADDR_W-1:0] paddr         = '0;
	logic [APB_DATA_W-1:0] pwdata        = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid      = 1'b0;
	logic                  in_ready;
	logic [1:0]            opcode        = OP_ALLOC;
	logic                  block_present = 1'b0;
	logic [BLK_W-1:0]      block_index   = '0;
	logic                  out_valid;
	logic                  out_ready     = 1'b0;
	logic [1:0]            status;
	logic [BLK_W-1:0]      granted_block;
	logic [CFG_W-1:0]      used_count;
	logic [CFG_W-1:0]      used_peak;

	int                    errors;
	int                    outstanding;
	int                    pool_size;
	logic [MAX_BLOCKS-1:0] live_map;
	logic [MAX_BLOCKS-1:0] seen_map;

	int   cycles       = 0;
	int   sent         = 0;
	int   idle_pct     = 20;
	bit   calm         = 1'b0;
	int   holds_asked  = 0;
	int   holds_served = 0;

	refcounted_block_allocator_top DUT (.*);
	rba_reply_checker reply_check (.*);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold on request
	initial begin
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (holds_served != holds_asked) begin
				out_ready <= 1'b0;
				repeat (80) @(negedge clk);
				holds_served++;
			end else if (!calm && $urandom_range(0, 99) < idle_pct / 2) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	task automatic send_item(logic [1:0] op, logic named, logic [BLK_W-1:0] idx);
		if (!calm && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		block_present <= named;
		block_index <= idx;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic configure(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		repeat (2) @(negedge clk);
	endtask

	// a marked block in the pool, scanning from a random start; -1 if none
	function automatic int find_block(logic [MAX_BLOCKS-1:0] map);
		int start;
		int b;
		start = $urandom_range(0, pool_size - 1);
		for (int k = 0; k < pool_size; k++) begin
			b = (start + k) % pool_size;
			if (map[b])
				return b;
		end
		return -1;
	endfunction

	// mostly allocate and release of live blocks; the rest is misuse and noise
	task automatic random_item(int alloc_pct);
		int         pick;
		int         b;
		logic [1:0] op;
		logic       named;
		op = $urandom_range(0, 1) ? OP_FREE : OP_ADDREF;
		named = 1'b1;
		b = $urandom_range(0, 1023);
		pick = $urandom_range(0, 99);
		if (pick < alloc_pct) begin
			op = OP_ALLOC;
			named = $urandom_range(0, 1);
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				op = OP_FREE;
				b = find_block(live_map);
			end else if (pick < 75) begin
				op = OP_ADDREF;
				b = find_block(live_map);
			end else if (pick < 83) begin
				b = find_block(seen_map);
			end else if (pick < 89 && pool_size < 1024) begin
				b = $urandom_range(pool_size, 1023);
			end else if (pick < 95) begin
				named = 1'b0;
			end else begin
				op = OP_UNUSED;
				named = $urandom_range(0, 1);
			end
			if (b < 0) begin
				op = OP_ALLOC;
				b = 0;
			end
		end
		send_item(op, named, b[BLK_W-1:0]);
	endtask

	task automatic run_random(int count, int alloc_pct);
		repeat (count) random_item(alloc_pct);
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: reset pool of 1024
		send_item(OP_FREE, 1'b0, 10'd1023);
		send_item(OP_ADDREF, 1'b0, 10'd0);
		send_item(OP_UNUSED, 1'b1, 10'd1023);
		send_item(OP_UNUSED, 1'b0, 10'd0);
		send_item(OP_ALLOC, 1'b1, 10'd1023);
		send_item(OP_ALLOC, 1'b0, 10'd0);
		send_item(OP_ADDREF, 1'b1, 10'd0);
		send_item(OP_FREE, 1'b1, 10'd0);
		send_item(OP_FREE, 1'b1, 10'd0);
		send_item(OP_FREE, 1'b1, 10'd0);
		send_item(OP_ADDREF, 1'b1, 10'd0);
		send_item(OP_ALLOC, 1'b1, 10'd0);
		send_item(OP_FREE, 1'b1, 10'd1);
		send_item(OP_ALLOC, 1'b0, 10'd1023);

		// zero clamps to a single block
		configure(POOL_ADDR, 32'd0);
		send_item(OP_ALLOC, 1'b1, 10'd5);
		send_item(OP_ALLOC, 1'b1, 10'd5);
		send_item(OP_FREE, 1'b1, 10'd1);
		send_item(OP_FREE, 1'b1, 10'd1023);
		send_item(OP_FREE, 1'b1, 10'd0);
		send_item(OP_ALLOC, 1'b0, 10'd0);
		run_random(40, 50);

		// full pool; long result hold, then a full drain mid-phase
		configure(POOL_ADDR, 32'd1024);
		run_random(100, 60);
		holds_asked++;
		run_random(80, 60);
		settle();
		run_random(70, 60);

		// over-range and upper-bit writes, and a write to an unused register
		configure(POOL_ADDR, 32'hFFFF_FFFF);
		run_random(40, 50);
		configure(POOL_ADDR, 32'h0001_0005);
		run_random(30, 45);
		configure(UNUSED_REG_ADDR, 32'd2);
		run_random(30, 45);

		// count saturation on a shared block
		idle_pct = 10;
		configure(POOL_ADDR, 32'd2);
		send_item(OP_ALLOC, 1'b0, 10'd0);
		send_item(OP_ALLOC, 1'b0, 10'd0);
		repeat (258) send_item(OP_ADDREF, 1'b1, 10'd1);
		repeat (3) send_item(OP_FREE, 1'b1, 10'd1);
		send_item(OP_FREE, 1'b1, 10'd0);

		while (sent < 1000) begin
			idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 35);
			if ($urandom_range(0, 4) == 0)
				configure(POOL_ADDR, $urandom_range(25, 1024));
			else
				configure(POOL_ADDR, $urandom_range(2, 24));
			run_random(60, $urandom_range(35, 60));
		end

		calm = 1'b1;
		configure(POOL_ADDR, 32'd8);
		run_random(100, 50);

		in_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
